### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

### design/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Types and constants shared by the fit-policy block allocator modules.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Field widths of the item and result ports
  localparam int OPCODE_W = 1;
  localparam int BLKNUM_W = 3;
  localparam int SIZEIO_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int POLICY_W   = 2;
  localparam int BLKUSE_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_RST = 2'd0;
  localparam logic [BLKUSE_W-1:0] BLKUSE_RST = 4'd8;

  // Placement policies
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

  // Parameter defaults
  localparam int BLOCKS_DEF     = 8;
  localparam int SIZE_WIDTH_DEF = 16;

  // Widest values the parameters allow; records between cells use these
  localparam int MAX_IDX_W  = 6;
  localparam int MAX_CNT_W  = 7;
  localparam int MAX_SIZE_W = 32;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Search parameters broadcast to every cell during a scan
  typedef struct packed {
    logic [POLICY_W-1:0]   policy;
    logic [MAX_CNT_W-1:0]  limit;   // entries taking part
    logic [MAX_IDX_W-1:0]  start;   // next-fit start entry
    logic [MAX_SIZE_W-1:0] size;    // requested size
  } scan_ctl_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  hi_found;  // first fit at or after start
    logic [MAX_IDX_W-1:0]  hi_pick;
    logic [MAX_SIZE_W-1:0] hi_val;
    logic                  lo_found;  // first fit before start
    logic [MAX_IDX_W-1:0]  lo_pick;
    logic [MAX_SIZE_W-1:0] lo_val;
    logic                  bt_found;  // best or worst fit so far
    logic [MAX_IDX_W-1:0]  bt_pick;
    logic [MAX_SIZE_W-1:0] bt_val;
  } scan_rec_t;

  // Entry write broadcast
  typedef struct packed {
    logic                  en;
    logic [MAX_IDX_W-1:0]  idx;
    logic [MAX_SIZE_W-1:0] data;
  } cell_wr_t;

endpackage

### design/fpba_cell.sv
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry of the allocator. Holds the entry's free size and folds it
// into the search token passing through, then hands the token on.
// ----------------------------------------------------------------------------
module fpba_cell #(
  parameter int CELL_IDX   = 0,
  parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpba_pkg::scan_ctl_t ctl,
  input  fpba_pkg::cell_wr_t  wr,
  input  fpba_pkg::scan_rec_t rec_in,
  output fpba_pkg::scan_rec_t rec_out
);
  import fpba_pkg::*;

  logic [SIZE_WIDTH-1:0] entry_r;
  scan_rec_t             rec_r;
  scan_rec_t             rec_nxt;
  logic [SIZE_WIDTH-1:0] req;
  logic [SIZE_WIDTH-1:0] bt_val;
  logic                  in_range;
  logic                  upper;
  logic                  fits;
  logic                  better;

  // Entry storage, cleared at reset, written by the controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (wr.en && wr.idx == MAX_IDX_W'(CELL_IDX)) begin
      entry_r <= SIZE_WIDTH'(wr.data);
    end
  end

  // Fold this entry into the token
  always_comb begin
    req      = SIZE_WIDTH'(ctl.size);
    bt_val   = SIZE_WIDTH'(rec_in.bt_val);
    in_range = MAX_CNT_W'(CELL_IDX) < ctl.limit;
    upper    = MAX_IDX_W'(CELL_IDX) >= ctl.start;
    fits     = in_range && (entry_r >= req);
    better   = !rec_in.bt_found ||
               (ctl.policy == POL_WORST && entry_r > bt_val) ||
               (ctl.policy == POL_BEST  && entry_r < bt_val);
    rec_nxt  = rec_in;
    if (fits && upper && !rec_in.hi_found) begin
      rec_nxt.hi_found = 1'b1;
      rec_nxt.hi_pick  = MAX_IDX_W'(CELL_IDX);
      rec_nxt.hi_val   = MAX_SIZE_W'(entry_r);
    end
    if (fits && !upper && !rec_in.lo_found) begin
      rec_nxt.lo_found = 1'b1;
      rec_nxt.lo_pick  = MAX_IDX_W'(CELL_IDX);
      rec_nxt.lo_val   = MAX_SIZE_W'(entry_r);
    end
    if (fits && better) begin
      rec_nxt.bt_found = 1'b1;
      rec_nxt.bt_pick  = MAX_IDX_W'(CELL_IDX);
      rec_nxt.bt_val   = MAX_SIZE_W'(entry_r);
    end
  end

  // Token register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_out = rec_r;

endmodule

### design/fit_policy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Fit-policy block allocator: next, worst or best fit over a table of free
// block sizes kept in a row of cells.
// ----------------------------------------------------------------------------
// A load item writes one table entry and returns the next-fit pointer to
// entry 0; it goes from acceptance straight to the finish state, where its
// result is registered into the output. An allocate item sends a search token
// down the row of BLOCKS cells, one cell per cycle, and passes through
// acceptance, the BLOCKS cell hops, capture of the token and the finish-state
// update. The finish state waits until the output register is free, so a
// stalled result keeps the block busy and holds up the next item's acceptance.
// Configuration writes are always taken and should only be made while no item
// is in flight.
module fit_policy_block_allocator_core #(
  parameter int BLOCKS     = fpba_pkg::BLOCKS_DEF,
  parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fpba_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [fpba_pkg::BLKNUM_W-1:0]   in_block_number,
  input  logic [fpba_pkg::SIZEIO_W-1:0]   in_size_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_granted,
  output logic [fpba_pkg::BLKNUM_W-1:0]   out_chosen_block,
  output logic [fpba_pkg::SIZEIO_W-1:0]   out_remaining_after,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpba_pkg::*;

  localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W = $clog2(BLOCKS + 1);

  // configuration registers
  logic [POLICY_W-1:0]   policy_r;
  logic [BLKUSE_W-1:0]   blkuse_r;

  // controller
  state_t                state_r, state_nxt;
  logic                  launch_r;
  logic [OPCODE_W-1:0]   op_r;
  logic [BLKNUM_W-1:0]   blk_r;
  logic [SIZE_WIDTH-1:0] size_r;
  scan_ctl_t             ctl_r;
  scan_rec_t             res_r;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic                  commit;
  logic [CNT_W-1:0]      limit;
  logic [IDX_W-1:0]      start;

  // finish stage
  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic [SIZE_WIDTH-1:0] pick_val;
  logic [SIZE_WIDTH-1:0] remain;
  cell_wr_t              wr;

  scan_rec_t             chain [BLOCKS+1];

  // output register
  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [BLKNUM_W-1:0]   out_chosen_r;
  logic [SIZEIO_W-1:0]   out_remain_r;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RST;
      blkuse_r <= BLKUSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY: policy_r <= cfg_data[POLICY_W-1:0];
        REG_BLOCKS: blkuse_r <= cfg_data[BLKUSE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Searched range and next-fit start entry
  always_comb begin
    limit = (32'(blkuse_r) > BLOCKS) ? CNT_W'(BLOCKS) : CNT_W'(blkuse_r);
    start = (CNT_W'(ptr_r) < limit) ? ptr_r : '0;
  end

  // Cell chain
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch_r;
  end

  for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
    fpba_cell #(
      .CELL_IDX   (g),
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl_r),
      .wr      (wr),
      .rec_in  (chain[g]),
      .rec_out (chain[g+1])
    );
  end

  // Result selection and table update
  always_comb begin
    found    = 1'b0;
    pick     = '0;
    pick_val = '0;
    ptr_nxt  = ptr_r;
    if (op_r == OP_LOAD) begin
      found    = 32'(blk_r) < BLOCKS;
      pick     = IDX_W'(blk_r);
      pick_val = size_r;
      if (found) begin
        ptr_nxt = '0;
      end
    end else begin
      case (ctl_r.policy) inside
        POL_NEXT: begin
          found    = res_r.hi_found || res_r.lo_found;
          pick     = res_r.hi_found ? IDX_W'(res_r.hi_pick) : IDX_W'(res_r.lo_pick);
          pick_val = res_r.hi_found ? SIZE_WIDTH'(res_r.hi_val)
                                    : SIZE_WIDTH'(res_r.lo_val);
          ptr_nxt  = found ? pick : IDX_W'(ctl_r.start);
        end
        POL_WORST, POL_BEST: begin
          found    = res_r.bt_found;
          pick     = IDX_W'(res_r.bt_pick);
          pick_val = SIZE_WIDTH'(res_r.bt_val);
        end
        default: ;
      endcase
    end
    remain = (op_r == OP_LOAD) ? pick_val : (pick_val - size_r);
  end

  always_comb begin
    wr.en   = commit && found;
    wr.idx  = MAX_IDX_W'(pick);
    wr.data = MAX_SIZE_W'(remain);
  end

  // Controller
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_FINISH) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_opcode == OP_ALLOC) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (chain[BLOCKS].valid) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      launch_r <= 1'b0;
      ptr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc && (in_opcode == OP_ALLOC);
      if (commit) begin
        ptr_r <= ptr_nxt;
      end
    end
  end

  // Item capture and token capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r         <= in_opcode;
      blk_r        <= in_block_number;
      size_r       <= SIZE_WIDTH'(in_size_value);
      ctl_r.policy <= policy_r;
      ctl_r.limit  <= MAX_CNT_W'(limit);
      ctl_r.start  <= MAX_IDX_W'(start);
      ctl_r.size   <= MAX_SIZE_W'(SIZE_WIDTH'(in_size_value));
    end
    if (state_r == ST_SCAN && chain[BLOCKS].valid) begin
      res_r <= chain[BLOCKS];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_granted_r <= found;
      out_chosen_r  <= found ? BLKNUM_W'(pick) : '0;
      out_remain_r  <= found ? SIZEIO_W'(remain) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted         = out_granted_r;
  assign out_chosen_block    = out_chosen_r;
  assign out_remaining_after = out_remain_r;

endmodule

### design/fpba_checker.sv
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks on the block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_granted,
  input logic [fpba_pkg::BLKNUM_W-1:0]   out_chosen_block,
  input logic [fpba_pkg::SIZEIO_W-1:0]   out_remaining_after
);
  import fpba_pkg::*;

  // one item at a time: an accepted item makes the block busy
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_granted) && $stable(out_chosen_block) && $stable(out_remaining_after))

  // a refused request reports zero block and zero size
  `ASSERT_CLK(a_refuse_zero, clk, rst_n, out_valid && !out_granted |-> out_chosen_block == '0 && out_remaining_after == '0)

  // reset empties the output
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fit-policy block allocator. A directed table
// covers loads, empty and full tables, zero requests, every placement policy,
// a clamped and a zero entry count and the disabled policy code. Random load
// and allocate traffic then runs under twelve register settings and three
// idle profiles. Every result is checked field by field against the typed
// expectation of its row, else an in-bench model of free sizes and fit pointer.
// ----------------------------------------------------------------------------
module tb_top;
  import fpba_pkg::*;

  localparam int NUM_BLOCKS = BLOCKS_DEF;
  localparam int SETTLE_CYC = NUM_BLOCKS + 8;

  // policy code that the block treats as "place nothing"
  localparam logic [POLICY_W-1:0] POL_HOLD = 2'd3;

  typedef struct packed {
    logic                granted;
    logic [BLKNUM_W-1:0] blk;
    logic [SIZEIO_W-1:0] rem;
  } alloc_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // code holds the opcode of an item or the register index of a write
  typedef struct packed {
    row_kind_t           kind;
    logic                code;
    logic [BLKNUM_W-1:0] blk;
    logic [SIZEIO_W-1:0] val;
    logic                typed;
    alloc_result_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [OPCODE_W-1:0] in_opcode;
  logic [BLKNUM_W-1:0] in_block_number;
  logic [SIZEIO_W-1:0] in_size_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_granted;
  logic [BLKNUM_W-1:0] out_chosen_block;
  logic [SIZEIO_W-1:0] out_remaining_after;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // typed expectation travelling with the item on the port
  logic          item_typed;
  alloc_result_t item_want;

  // model state
  logic [SIZEIO_W-1:0] free_left [NUM_BLOCKS];
  logic [BLKNUM_W-1:0] fit_ptr;
  logic [POLICY_W-1:0] cur_policy;
  logic [BLKUSE_W-1:0] cur_blocks;

  alloc_result_t pending_grants[$];
  stim_row_t     dir_rows[$];

  int send_gap_pct;
  int stall_pct;
  int n_errors;
  int n_accepted;
  int n_checked;
  int n_granted;
  int n_cfg_writes;

  // settings for the random segments, extremes included
  logic [POLICY_W-1:0] seg_policy [0:11] = '{POL_NEXT, POL_WORST, POL_BEST, POL_NEXT,
                                             POL_BEST, POL_WORST, POL_HOLD, POL_NEXT,
                                             POL_BEST, POL_WORST, POL_NEXT, POL_BEST};
  logic [BLKUSE_W-1:0] seg_blocks [0:11] = '{4'd8, 4'd8, 4'd8, 4'd1,
                                             4'd15, 4'd3, 4'd8, 4'd5,
                                             4'd2, 4'd0, 4'd12, 4'd7};

  fit_policy_block_allocator_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_block_number     (in_block_number),
    .in_size_value       (in_size_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted         (out_granted),
    .out_chosen_block    (out_chosen_block),
    .out_remaining_after (out_remaining_after),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_grants.size());
    $display("** fit_policy_block_allocator_core: FAILED **");
    $finish;
  end

  task automatic flag(input string what, input int unsigned got, input int unsigned want);
    n_errors++;
    $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Place one item against the table; updates table and pointer.
  function automatic alloc_result_t place_request(input logic [OPCODE_W-1:0] op,
                                                  input logic [BLKNUM_W-1:0] blk,
                                                  input logic [SIZEIO_W-1:0] size);
    alloc_result_t r;
    int            lim;
    int            j;
    int            pick;
    bit            found;
    r     = '0;
    pick  = 0;
    found = 1'b0;
    lim   = (cur_blocks > NUM_BLOCKS) ? NUM_BLOCKS : cur_blocks;
    if (op == OP_LOAD) begin
      free_left[blk] = size;
      fit_ptr        = '0;
      r.granted      = 1'b1;
      r.blk          = blk;
      r.rem          = size;
      return r;
    end
    if (cur_policy == POL_NEXT) begin
      // circular search from the kept pointer
      j = (fit_ptr < lim) ? fit_ptr : 0;
      for (int i = 0; i < lim; i++) begin
        if (!found) begin
          if (free_left[BLKNUM_W'(j)] >= size) begin
            found = 1'b1;
            pick  = j;
          end else begin
            j = (j + 1 < lim) ? j + 1 : 0;
          end
        end
      end
      fit_ptr = found ? BLKNUM_W'(pick) : BLKNUM_W'(j);
    end else if (cur_policy == POL_WORST || cur_policy == POL_BEST) begin
      // largest or smallest fitting entry, lowest index on ties
      for (int i = 0; i < lim; i++) begin
        if (free_left[BLKNUM_W'(i)] >= size) begin
          if (!found ||
              (cur_policy == POL_WORST &&
               free_left[BLKNUM_W'(i)] > free_left[BLKNUM_W'(pick)]) ||
              (cur_policy == POL_BEST &&
               free_left[BLKNUM_W'(i)] < free_left[BLKNUM_W'(pick)])) begin
            found = 1'b1;
            pick  = i;
          end
        end
      end
    end
    if (!found)
      return r;
    free_left[BLKNUM_W'(pick)] = free_left[BLKNUM_W'(pick)] - size;
    r.granted       = 1'b1;
    r.blk           = BLKNUM_W'(pick);
    r.rem           = free_left[BLKNUM_W'(pick)];
    return r;
  endfunction

  // Port watch: predict on item acceptance, check on result acceptance.
  always @(posedge clk) begin : port_watch
    alloc_result_t r;
    alloc_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        r = place_request(in_opcode, in_block_number, in_size_value);
        pending_grants.push_back(item_typed ? item_want : r);
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          flag("unexpected result", 32'(out_chosen_block), 0);
        end else begin
          want = pending_grants.pop_front();
          n_checked++;
          n_granted += 32'(out_granted);
          if (out_granted !== want.granted)
            flag("granted", 32'(out_granted), 32'(want.granted));
          if (out_chosen_block !== want.blk)
            flag("chosen_block", 32'(out_chosen_block), 32'(want.blk));
          if (out_remaining_after !== want.rem)
            flag("remaining_after", 32'(out_remaining_after), 32'(want.rem));
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk)
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

  function automatic void add_row(input row_kind_t kind, input logic code,
                                  input logic [BLKNUM_W-1:0] blk,
                                  input logic [SIZEIO_W-1:0] val, input logic typed,
                                  input logic g, input logic [BLKNUM_W-1:0] b,
                                  input logic [SIZEIO_W-1:0] rem);
    stim_row_t row;
    row.kind         = kind;
    row.code         = code;
    row.blk          = blk;
    row.val          = val;
    row.typed        = typed;
    row.want.granted = g;
    row.want.blk     = b;
    row.want.rem     = rem;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [BLKNUM_W-1:0] blk,
                           input logic [SIZEIO_W-1:0] size, input logic typed,
                           input alloc_result_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_block_number <= blk;
    in_size_value   <= size;
    item_typed      <= typed;
    item_want       <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every result is back and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_POLICY)
      cur_policy = data[POLICY_W-1:0];
    else
      cur_blocks = data[BLKUSE_W-1:0];
    n_cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random item: well-formed loads and requests sized against the table.
  task automatic pick_random_item(output logic [OPCODE_W-1:0] op,
                                  output logic [BLKNUM_W-1:0] blk,
                                  output logic [SIZEIO_W-1:0] size);
    logic [SIZEIO_W-1:0] have;
    have = free_left[BLKNUM_W'($urandom_range(0, NUM_BLOCKS - 1))];
    blk  = BLKNUM_W'($urandom_range(0, NUM_BLOCKS - 1));
    if ($urandom_range(0, 99) < 25) begin
      op = OP_LOAD;
      case ($urandom_range(0, 4))
        0: size = SIZEIO_W'($urandom_range(0, 255));
        1: size = SIZEIO_W'($urandom_range(0, 4095));
        2: size = '1;
        3: size = '0;
        default: size = SIZEIO_W'($urandom);
      endcase
    end else begin
      op = OP_ALLOC;
      case ($urandom_range(0, 6))
        0: size = SIZEIO_W'($urandom);
        1: size = '0;
        2: size = have;
        3: size = have + 1'b1;
        default: size = SIZEIO_W'($urandom_range(0, have));
      endcase
    end
  endtask

  initial begin
    logic [OPCODE_W-1:0] op;
    logic [BLKNUM_W-1:0] blk;
    logic [SIZEIO_W-1:0] size;
    int                  idx;
    int                  n_items;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_LOAD;
    in_block_number = '0;
    in_size_value   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_POLICY;
    cfg_data        = '0;
    item_typed      = 1'b0;
    item_want       = '0;
    send_gap_pct    = 13;
    stall_pct       = 77;
    n_errors        = 0;
    n_accepted      = 0;
    n_checked       = 0;
    n_granted       = 0;
    n_cfg_writes    = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) free_left[BLKNUM_W'(i)] = '0;
    fit_ptr    = '0;
    cur_policy = POLICY_RST;
    cur_blocks = BLKUSE_RST;

    // directed table: empty table, loads, each policy, range and policy corners
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd1,     1'b1, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd7, 16'd0,     1'b1, 1'b1, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_LOAD,  3'd0, 16'd100,   1'b1, 1'b1, 3'd0, 16'd100);
    add_row(ROW_ITEM, OP_LOAD,  3'd7, 16'hFFFF,  1'b1, 1'b1, 3'd7, 16'hFFFF);
    add_row(ROW_ITEM, OP_LOAD,  3'd3, 16'd40,    1'b1, 1'b1, 3'd3, 16'd40);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd50,    1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd5, 16'd60,    1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'hFFFF,  1'b1, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_POLICY, 3'd0, 16'(POL_WORST), 1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd10,    1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_POLICY, 3'd0, 16'(POL_BEST),  1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd30,    1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'hFFFF,  1'b1, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_BLOCKS, 3'd0, 16'd0,   1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd0,     1'b1, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_BLOCKS, 3'd0, 16'd15,  1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd0,     1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_POLICY, 3'd0, 16'(POL_NEXT),  1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_BLOCKS, 3'd0, 16'd1,   1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd1,     1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_LOAD,  3'd5, 16'd7,     1'b1, 1'b1, 3'd5, 16'd7);
    add_row(ROW_CFG,  REG_POLICY, 3'd0, 16'(POL_HOLD),  1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd0,     1'b1, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_POLICY, 3'd0, 16'(POL_NEXT),  1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_BLOCKS, 3'd0, 16'd8,   1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_LOAD,  3'd6, 16'd500,   1'b1, 1'b1, 3'd6, 16'd500);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd400,   1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd200,   1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_CFG,  REG_BLOCKS, 3'd0, 16'd4,   1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'd5,     1'b0, 1'b0, 3'd0, 16'd0);
    add_row(ROW_ITEM, OP_ALLOC, 3'd0, 16'hFFFF,  1'b1, 1'b0, 3'd0, 16'd0);

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[k].code, dir_rows[k].val[CFG_DATA_W-1:0]);
      end else begin
        send_item(dir_rows[k].code, dir_rows[k].blk, dir_rows[k].val,
                  dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // random part: three idle profiles, four register settings each
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 13 : (ph == 1) ? 77 : 0;
      stall_pct    = (ph == 0) ? 77 : (ph == 1) ? 13 : 0;
      for (int s = 0; s < 4; s++) begin
        idx = ph * 4 + s;
        settle();
        write_reg(REG_POLICY, CFG_DATA_W'(seg_policy[idx]));
        write_reg(REG_BLOCKS, seg_blocks[idx]);
        // settings that can grant nothing get a short segment
        n_items = (seg_policy[idx] == POL_HOLD || seg_blocks[idx] == 0) ? 30 : 190;
        for (int k = 0; k < n_items; k++) begin
          if (k == n_items / 2)
            settle();
          pick_random_item(op, blk, size);
          send_item(op, blk, size, 1'b0, '0);
        end
      end
    end

    // drain and look for stray results
    settle();
    if (pending_grants.size() != 0)
      flag("results never delivered", 0, pending_grants.size());

    $display("covered %0d items, %0d results checked, %0d granted, %0d refused",
             n_accepted, n_checked, n_granted, n_checked - n_granted);
    $display("%0d register writes over all policies and entry counts 0 to 15",
             n_cfg_writes);
    if (n_errors == 0)
      $display("** fit_policy_block_allocator_core: PASSED **");
    else
      $display("** fit_policy_block_allocator_core: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/fpba_pkg.sv
design/fpba_cell.sv
design/fit_policy_block_allocator_core.sv
design/fpba_checker.sv
sim/tb_top.sv
